/* design/string_id_auth_code_hash_top_macros.svh */
// assertion macros shared by the checker
`ifndef STRING_ID_AUTH_CODE_HASH_TOP_MACROS_SVH
`define STRING_ID_AUTH_CODE_HASH_TOP_MACROS_SVH

// property checked on every clock edge, ignored while in reset
`define SHAC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define SHAC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/shac_pkg.sv */
package shac_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned FWD_SHIFT = 3;
  localparam int unsigned BWD_SHIFT = 4;

  // per-index multipliers, 1 + 2^(shift + parity)
  localparam logic [WORD_W-1:0] FWD_MUL_EVEN = WORD_W'(1) + (WORD_W'(1) << FWD_SHIFT);
  localparam logic [WORD_W-1:0] FWD_MUL_ODD  = WORD_W'(1) + (WORD_W'(1) << (FWD_SHIFT + 1));
  localparam logic [WORD_W-1:0] BWD_MUL_EVEN = WORD_W'(1) + (WORD_W'(1) << BWD_SHIFT);
  localparam logic [WORD_W-1:0] BWD_MUL_ODD  = WORD_W'(1) + (WORD_W'(1) << (BWD_SHIFT + 1));

  // byte-permuted id, a zero b2 or b3 replaced by the complement of its partner
  function automatic logic [WORD_W-1:0] mix_id(input logic [WORD_W-1:0] id);
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic [BYTE_W-1:0] b3;
    logic [BYTE_W-1:0] hi_mid;
    logic [BYTE_W-1:0] low;
    b0 = id[7:0];
    b1 = id[15:8];
    b2 = id[23:16];
    b3 = id[31:24];
    hi_mid = (b2 != '0) ? b2 : ~b1;
    low    = (b3 != '0) ? b3 : ~b0;
    return {b0, hi_mid, b1, low};
  endfunction

endpackage

/* design/shac_if.sv */
interface shac_byte_if;
  logic                               valid;
  logic                               ready;
  logic [shac_pkg::BYTE_W-1:0]        song_byte;
  logic                               is_last;
  logic [shac_pkg::WORD_W-1:0]        track_id;

  modport source (output valid, song_byte, is_last, track_id, input ready);
  modport sink   (input valid, song_byte, is_last, track_id, output ready);
endinterface

interface shac_code_if;
  logic                               valid;
  logic                               ready;
  logic signed [shac_pkg::WORD_W-1:0] auth_code;

  modport source (output valid, auth_code, input ready);
  modport sink   (input valid, auth_code, output ready);
endinterface

/* design/shac_mul.sv */
module shac_mul (
  input  logic                        clk,
  input  logic [shac_pkg::WORD_W-1:0] a,
  input  logic [shac_pkg::WORD_W-1:0] b,
  output logic [shac_pkg::WORD_W-1:0] prod
);

  // low word of the product, registered
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

/* design/string_id_auth_code_hash_top.sv */
// String id authentication code. The block takes a byte string one byte per
// item on the bytes channel (bytes read as signed 8-bit values) and, on the
// byte flagged is_last, gives one signed 32-bit auth_code on the codes channel
// built from a forward hash, a backward hash and the track_id carried with
// that last byte. All arithmetic wraps modulo 2^32. Every product goes
// through a single registered 32x32 multiplier stepped by a small sequencer:
// a byte that is not last holds the block through S_F, S_B, S_W and S_WD (three
// products plus write-back) before ready comes back, and the last byte goes
// on through S_M1, S_M2 and S_M3, its code reaching the output register as
// the block turns ready. The output register lets the next string start while
// a code waits to be taken; a second code waits in the sequencer until the
// first one leaves. Hash state returns to its reset values after each string.
module string_id_auth_code_hash_top (
  input  logic       clk,
  input  logic       rst,
  shac_byte_if.sink  bytes,
  shac_code_if.source codes
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_F,    // forward hash times its multiplier
    S_B,    // byte times backward weight
    S_W,    // weight times backward multiplier
    S_WD,   // weight write-back, first code term
    S_M1,   // term times (fwd | mix)
    S_M2,   // times (bwd ^ id)
    S_M3    // wait for the output register
  } state_t;

  state_t                        state;
  logic [shac_pkg::WORD_W-1:0]   fwd;     // forward hash
  logic [shac_pkg::WORD_W-1:0]   bwd;     // backward hash
  logic [shac_pkg::WORD_W-1:0]   weight;  // running product of backward multipliers
  logic                          odd;     // parity of the byte index
  logic [shac_pkg::WORD_W-1:0]   chr;     // sign-extended byte
  logic                          last;
  logic [shac_pkg::WORD_W-1:0]   id;
  logic [shac_pkg::WORD_W-1:0]   term;    // (bwd ^ mix) + (fwd | id)
  logic [shac_pkg::WORD_W-1:0]   code;
  logic                          code_valid;

  logic [shac_pkg::WORD_W-1:0]   mul_a;
  logic [shac_pkg::WORD_W-1:0]   mul_b;
  logic [shac_pkg::WORD_W-1:0]   prod;
  logic [shac_pkg::WORD_W-1:0]   mix;

  assign mix = shac_pkg::mix_id(id);

  // the shared multiplier, product in the cycle after its operands
  shac_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // operand selection per sequencer step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_F: begin
        mul_a = fwd;
        mul_b = odd ? shac_pkg::FWD_MUL_ODD : shac_pkg::FWD_MUL_EVEN;
      end
      S_B: begin
        mul_a = chr;
        mul_b = weight;
      end
      S_W: begin
        mul_a = weight;
        mul_b = odd ? shac_pkg::BWD_MUL_ODD : shac_pkg::BWD_MUL_EVEN;
      end
      S_M1: begin
        mul_a = term;
        mul_b = fwd | mix;
      end
      S_M2: begin
        mul_a = prod;
        mul_b = bwd ^ id;
      end
      S_M3: begin
        // keep the finished code in the product register while stalled
        mul_a = prod;
        mul_b = shac_pkg::WORD_W'(1);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign bytes.ready     = (state == S_IDLE);
  assign codes.valid     = code_valid;
  assign codes.auth_code = $signed(code);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fwd        <= '0;
      bwd        <= '0;
      weight     <= shac_pkg::WORD_W'(1);
      odd        <= 1'b0;
      code_valid <= 1'b0;
    end else begin
      // in S_M3 the sequencer itself decides on the output register
      if (code_valid && codes.ready && state != S_M3) begin
        code_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (bytes.valid) begin
            chr   <= {{(shac_pkg::WORD_W - shac_pkg::BYTE_W){bytes.song_byte[7]}},
                      bytes.song_byte};
            last  <= bytes.is_last;
            id    <= bytes.track_id;
            state <= S_F;
          end
        end
        S_F: begin
          state <= S_B;
        end
        S_B: begin
          fwd   <= chr + prod;
          state <= S_W;
        end
        S_W: begin
          bwd   <= bwd + prod;
          state <= S_WD;
        end
        S_WD: begin
          weight <= prod;
          odd    <= ~odd;
          if (last) begin
            term  <= (bwd ^ mix) + (fwd | id);
            state <= S_M1;
          end else begin
            state <= S_IDLE;
          end
        end
        S_M1: begin
          state <= S_M2;
        end
        S_M2: begin
          state <= S_M3;
        end
        S_M3: begin
          if (!code_valid || codes.ready) begin
            code       <= prod;
            code_valid <= 1'b1;
            // string done, back to reset values
            fwd        <= '0;
            bwd        <= '0;
            weight     <= shac_pkg::WORD_W'(1);
            odd        <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/shac_chk.sv */
`include "string_id_auth_code_hash_top_macros.svh"

module shac_chk (
  input logic clk,
  input logic rst,
  input logic bytes_valid,
  input logic bytes_ready,
  input logic bytes_is_last,
  input logic codes_valid,
  input logic codes_ready
);

  // no code comes out of reset
  `SHAC_ASSERT_ALWAYS(a_rst_no_code, rst |=> !codes_valid, "code valid right after reset")

  // a waiting code stays until taken
  `SHAC_ASSERT(a_code_hold, codes_valid && !codes_ready |=> codes_valid, "code dropped")

  // the block is busy right after taking an item
  `SHAC_ASSERT(a_busy, bytes_valid && bytes_ready |=> !bytes_ready, "ready after accept")

  // a byte that is not last frees the block after its fixed step count
  `SHAC_ASSERT(a_byte_turn, bytes_valid && bytes_ready && !bytes_is_last |-> ##5 bytes_ready, "byte step count off")

endmodule

bind string_id_auth_code_hash_top shac_chk u_shac_chk (
  .clk           (clk),
  .rst           (rst),
  .bytes_valid   (bytes.valid),
  .bytes_ready   (bytes.ready),
  .bytes_is_last (bytes.is_last),
  .codes_valid   (codes.valid),
  .codes_ready   (codes.ready)
);

/* test/string_id_auth_code_hash_top_tb.sv */
`timescale 1ns / 1ps

module string_id_auth_code_hash_top_tb;

  localparam int unsigned CLK_PERIOD   = 8;
  localparam int unsigned RESET_CYCLES = 5;
  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned MAX_GAP      = 9;

  // scoreboard: tracks both hashes over the bytes seen so far and queues
  // the code that each last byte must produce
  class auth_code_scoreboard;
    logic [31:0] fwd_hash;
    logic [31:0] bwd_hash;
    logic [31:0] bwd_weight;
    bit          odd_index;
    logic [31:0] expected_codes[$];
    int          mismatches;

    function new();
      clear_hashes();
      mismatches = 0;
    endfunction

    function void clear_hashes();
      fwd_hash   = 32'h0;
      bwd_hash   = 32'h0;
      bwd_weight = 32'h1;
      odd_index  = 1'b0;
    endfunction

    function int pending();
      return expected_codes.size();
    endfunction

    function void note_byte(logic [7:0] song_byte, logic is_last, logic [31:0] track_id);
      logic [31:0] c;
      logic [31:0] fwd_mul;
      logic [31:0] bwd_mul;
      logic [7:0]  mid;
      logic [7:0]  lo;
      logic [31:0] mixed;
      logic [31:0] code;
      c       = {{24{song_byte[7]}}, song_byte};
      fwd_mul = 32'h1 + (32'h1 << (3 + odd_index));
      bwd_mul = 32'h1 + (32'h1 << (4 + odd_index));
      fwd_hash   = c + fwd_hash * fwd_mul;
      bwd_hash   = bwd_hash + c * bwd_weight;
      bwd_weight = bwd_weight * bwd_mul;
      odd_index  = !odd_index;
      if (is_last) begin
        mid   = (track_id[23:16] != 8'h00) ? track_id[23:16] : ~track_id[15:8];
        lo    = (track_id[31:24] != 8'h00) ? track_id[31:24] : ~track_id[7:0];
        mixed = {track_id[7:0], mid, track_id[15:8], lo};
        code  = ((bwd_hash ^ mixed) + (fwd_hash | track_id)) * (fwd_hash | mixed) *
                (bwd_hash ^ track_id);
        expected_codes.push_back(code);
        clear_hashes();
      end
    endfunction

    task report(string msg);
      mismatches++;
      $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    task check_code(logic signed [31:0] auth_code);
      logic [31:0] want;
      if (expected_codes.size() == 0) begin
        report($sformatf("unexpected auth_code %h", auth_code));
      end else begin
        want = expected_codes.pop_front();
        if (auth_code !== want)
          report($sformatf("auth_code %h, expected %h", auth_code, want));
      end
    endtask
  endclass

  logic clk;
  logic rst;

  shac_byte_if byte_ch ();
  shac_code_if code_ch ();

  string_id_auth_code_hash_top u_dut (
    .clk   (clk),
    .rst   (rst),
    .bytes (byte_ch),
    .codes (code_ch)
  );

  auth_code_scoreboard sb = new();

  // idle controls, switched between phases of the random part
  bit sender_idles;
  bit receiver_idles;
  int sent_items;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // watchdog for a hung handshake
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("ERROR: cycle limit reached with %0d codes outstanding", sb.pending());
    $display("string_id_auth_code_hash_top regression: fail");
    $finish;
  end

  // one byte item: optional gap with valid low, then hold valid until taken
  task automatic send_byte(input logic [7:0] song_byte, input logic is_last,
                           input logic [31:0] track_id);
    int gap;
    gap = sender_idles ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      @(negedge clk);
      byte_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    byte_ch.valid     = 1'b1;
    byte_ch.song_byte = song_byte;
    byte_ch.is_last   = is_last;
    byte_ch.track_id  = track_id;
    do @(posedge clk); while (!byte_ch.ready);
    sb.note_byte(song_byte, is_last, track_id);
    sent_items++;
  endtask

  task automatic drop_valid();
    @(negedge clk);
    byte_ch.valid = 1'b0;
  endtask

  // id with each byte forced to zero now and then, to hit the complement paths
  function automatic logic [31:0] random_track_id();
    logic [31:0] id;
    id = $urandom();
    for (int k = 0; k < 4; k++)
      if ($urandom_range(0, 3) == 0) id[8*k +: 8] = 8'h00;
    return id;
  endfunction

  // string of random bytes; non-last bytes carry junk ids that must be ignored
  task automatic send_random_string(input int len);
    for (int k = 0; k < len; k++)
      send_byte(8'($urandom()), k == len - 1, k == len - 1 ? random_track_id() : $urandom());
  endtask

  // code receiver: random stall per item, code checked at the accepting edge
  initial begin
    int gap;
    code_ch.ready = 1'b0;
    @(negedge clk iff !rst);
    forever begin
      gap = receiver_idles ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
        @(negedge clk);
        code_ch.ready = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      code_ch.ready = 1'b1;
      do @(posedge clk); while (!code_ch.valid);
      sb.check_code(code_ch.auth_code);
    end
  end

  initial begin
    bit paused;
    int len;
    rst               = 1'b1;
    byte_ch.valid     = 1'b0;
    byte_ch.song_byte = 8'h00;
    byte_ch.is_last   = 1'b0;
    byte_ch.track_id  = 32'h0;
    sender_idles      = 1'b1;
    receiver_idles    = 1'b1;
    sent_items        = 0;
    paused            = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // single-byte strings at the byte extremes, ids with and without zero bytes
    send_byte(8'h00, 1'b1, 32'h0000_0000);
    send_byte(8'hff, 1'b1, 32'hffff_ffff);
    send_byte(8'h80, 1'b1, 32'h8000_0000);
    send_byte(8'h7f, 1'b1, 32'h7fff_ffff);
    send_byte(8'h01, 1'b1, 32'h0000_1234);  // both upper id bytes zero
    send_byte(8'hfe, 1'b1, 32'h1200_3456);  // id[23:16] zero only
    send_byte(8'h55, 1'b1, 32'h0012_3456);  // id[31:24] zero only
    send_byte(8'haa, 1'b1, 32'h1234_5678);  // no zero bytes
    send_byte(8'h80, 1'b1, 32'h0000_00ff);

    // multi-byte strings, odd and even lengths, junk ids on the inner bytes
    send_byte(8'h80, 1'b0, 32'hdead_beef);
    send_byte(8'h7f, 1'b0, 32'hffff_ffff);
    send_byte(8'hff, 1'b1, 32'h00ff_00ff);
    send_byte(8'hff, 1'b0, 32'h0);
    send_byte(8'hff, 1'b0, 32'h0);
    send_byte(8'hff, 1'b0, 32'h0);
    send_byte(8'hff, 1'b1, 32'hff00_ff00);
    send_byte(8'h00, 1'b0, 32'h5555_5555);
    send_byte(8'h00, 1'b1, 32'haaaa_aaaa);

    // a new string starts right after a last byte with no idling on either side
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    send_byte(8'h7f, 1'b1, 32'h0102_0304);
    send_byte(8'h80, 1'b0, 32'h0);
    send_byte(8'h81, 1'b1, 32'h0400_0300);

    // random strings, mostly short, some long; idle mode reshuffled now and then
    sent_items = 0;
    while (sent_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) == 0)
        {sender_idles, receiver_idles} = 2'($urandom_range(0, 3));
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 32) : $urandom_range(1, 6);
      send_random_string(len);
      // hold the byte side until every code has drained, once mid-run
      if (!paused && sent_items >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        drop_valid();
        while (sb.pending() != 0) @(posedge clk);
      end
    end

    drop_valid();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("string_id_auth_code_hash_top regression: pass");
    else
      $display("string_id_auth_code_hash_top regression: fail");
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/shac_pkg.sv
design/shac_if.sv
design/shac_mul.sv
design/string_id_auth_code_hash_top.sv
design/shac_chk.sv
test/string_id_auth_code_hash_top_tb.sv
